@@ hw/rtl/fpec_pkg.sv @@
`timescale 1ns / 1ps
// shared constants, types and pair tables of the four point enclosure check
package fpec_pkg;

	localparam int COORD_BITS_DEFAULT  = 26;
	localparam int RADIUS_BITS_DEFAULT = 8;
	localparam int RADIUS_RESET        = 128;
	localparam int NUM_POINTS          = 4;
	localparam int NUM_PAIRS           = 6;

	// flags that travel down the chain with each candidate centre
	typedef struct packed {
		logic valid;
		logic ok;
	} fpec_tag_t;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_PAIR  = 5'b00010,
		S_SCAN  = 5'b00100,
		S_DRAIN = 5'b01000,
		S_DONE  = 5'b10000
	} fpec_state_t;

	localparam logic [1:0] PAIR_A [NUM_PAIRS] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
	localparam logic [1:0] PAIR_B [NUM_PAIRS] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

endpackage

@@ hw/rtl/fpec_pair_check.sv @@
`timescale 1ns / 1ps
// rejection test for one pair of points against twice the radius
module fpec_pair_check #(
	parameter int COORD_BITS  = fpec_pkg::COORD_BITS_DEFAULT,
	parameter int RADIUS_BITS = fpec_pkg::RADIUS_BITS_DEFAULT
) (
	input  logic signed [COORD_BITS-1:0] ax,
	input  logic signed [COORD_BITS-1:0] az,
	input  logic signed [COORD_BITS-1:0] bx,
	input  logic signed [COORD_BITS-1:0] bz,
	input  logic [RADIUS_BITS-1:0]       radius,
	output logic                         reject
);
	import fpec_pkg::*;

	localparam int SQ = 2 * RADIUS_BITS + 2;

	logic signed [COORD_BITS:0] dx_s, dz_s;
	logic [COORD_BITS:0]        dx_a, dz_a;
	logic [RADIUS_BITS:0]       twice;
	logic [RADIUS_BITS:0]       side;
	logic                       far;
	logic [SQ:0]                sum;
	logic [SQ-1:0]              lim;

	always_comb begin
		dx_s  = $signed({ax[COORD_BITS-1], ax}) - $signed({bx[COORD_BITS-1], bx});
		dz_s  = $signed({az[COORD_BITS-1], az}) - $signed({bz[COORD_BITS-1], bz});
		dx_a  = dx_s[COORD_BITS] ? (COORD_BITS+1)'(0) - dx_s : dx_s;
		dz_a  = dz_s[COORD_BITS] ? (COORD_BITS+1)'(0) - dz_s : dz_s;
		twice = {radius, 1'b0};
		side  = {radius, 1'b1};
		// beyond 2r on one axis already rejects; otherwise the squares stay narrow
		far   = (dx_a > (COORD_BITS+1)'(twice)) || (dz_a > (COORD_BITS+1)'(twice));
		lim   = SQ'(side) * SQ'(side);
		sum   = (SQ+1)'(dx_a[RADIUS_BITS:0]) * (SQ+1)'(dx_a[RADIUS_BITS:0])
		      + (SQ+1)'(dz_a[RADIUS_BITS:0]) * (SQ+1)'(dz_a[RADIUS_BITS:0]);
		reject = far || (sum >= (SQ+1)'(lim));
	end

endmodule

@@ hw/rtl/fpec_cell.sv @@
`timescale 1ns / 1ps
// one cell of the distance chain: holds a point, tests each passing centre
module fpec_cell #(
	parameter int COORD_BITS  = fpec_pkg::COORD_BITS_DEFAULT,
	parameter int RADIUS_BITS = fpec_pkg::RADIUS_BITS_DEFAULT,
	parameter int CW          = COORD_BITS + 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  logic signed [COORD_BITS-1:0] px,
	input  logic signed [COORD_BITS-1:0] pz,
	input  logic [2*RADIUS_BITS-1:0]     r2,
	input  logic signed [CW-1:0]         x_in,
	input  logic signed [CW-1:0]         z_in,
	input  fpec_pkg::fpec_tag_t          tag_in,
	output logic signed [CW-1:0]         x_out,
	output logic signed [CW-1:0]         z_out,
	output fpec_pkg::fpec_tag_t          tag_out
);
	import fpec_pkg::*;

	localparam int SQ = 2 * RADIUS_BITS + 2;

	logic signed [COORD_BITS-1:0] px_q, pz_q;
	logic signed [CW-1:0]         dx_s, dz_s, dx_a, dz_a;
	logic [SQ:0]                  sum;
	logic                         inside_r;

	always_ff @(posedge clk) begin
		if (load) begin
			px_q <= px;
			pz_q <= pz;
		end
	end

	always_comb begin
		dx_s = x_in - {{(CW-COORD_BITS){px_q[COORD_BITS-1]}}, px_q};
		dz_s = z_in - {{(CW-COORD_BITS){pz_q[COORD_BITS-1]}}, pz_q};
		dx_a = dx_s[CW-1] ? CW'(0) - dx_s : dx_s;
		dz_a = dz_s[CW-1] ? CW'(0) - dz_s : dz_s;
		// inside the window every offset is at most 2r
		sum  = (SQ+1)'(dx_a[RADIUS_BITS:0]) * (SQ+1)'(dx_a[RADIUS_BITS:0])
		     + (SQ+1)'(dz_a[RADIUS_BITS:0]) * (SQ+1)'(dz_a[RADIUS_BITS:0]);
		inside_r = sum <= (SQ+1)'(r2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_out <= '0;
		end else begin
			tag_out.valid <= tag_in.valid;
			tag_out.ok    <= tag_in.ok && inside_r;
		end
	end

	always_ff @(posedge clk) begin
		x_out <= x_in;
		z_out <= z_in;
	end

endmodule

@@ hw/rtl/four_point_enclosure_check_unit.sv @@
`timescale 1ns / 1ps
// four point enclosure check: pair test, then a scan of candidate centres
// through a chain of four distance cells, one centre entering per cycle.
// steps: the pair test, the scan of the centre window, the drain of the chain, then the output register.
// a rejected set ends after the failing pair.
// one item at a time; the next is taken once the result sits in the output register.
// arst_n clears control state and sets the radius to 128.
module four_point_enclosure_check_unit #(
	parameter int COORD_BITS  = fpec_pkg::COORD_BITS_DEFAULT,
	parameter int RADIUS_BITS = fpec_pkg::RADIUS_BITS_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [RADIUS_BITS-1:0]       radius,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] first_x,
	input  logic signed [COORD_BITS-1:0] first_z,
	input  logic signed [COORD_BITS-1:0] second_x,
	input  logic signed [COORD_BITS-1:0] second_z,
	input  logic signed [COORD_BITS-1:0] third_x,
	input  logic signed [COORD_BITS-1:0] third_z,
	input  logic signed [COORD_BITS-1:0] fourth_x,
	input  logic signed [COORD_BITS-1:0] fourth_z,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         enclosed
);
	import fpec_pkg::*;

	localparam int CW = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;
	localparam int DW = $clog2(NUM_POINTS + 1);

	fpec_state_t state_q;
	logic [RADIUS_BITS-1:0]       radius_q;
	logic signed [COORD_BITS-1:0] px_q [NUM_POINTS];
	logic signed [COORD_BITS-1:0] pz_q [NUM_POINTS];
	logic signed [COORD_BITS-1:0] sx_q [NUM_POINTS];
	logic signed [COORD_BITS-1:0] sz_q [NUM_POINTS];
	logic signed [COORD_BITS-1:0] sx_n [NUM_POINTS];
	logic signed [COORD_BITS-1:0] sz_n [NUM_POINTS];
	logic signed [COORD_BITS-1:0] tmp;
	logic [2:0]                   pair_q;
	logic [DW-1:0]                drain_q;
	logic signed [CW-1:0]         x_q, z_q, xlo_q, zlo_q, xhi_q, zhi_q;
	logic signed [CW-1:0]         xlo, xhi, zlo, zhi, rad_w;
	logic                         hit_q, out_valid_q, enclosed_q;
	logic                         reject, in_acc, last_cand, hit_now, done_fire;
	logic [2*RADIUS_BITS-1:0]     r2;

	logic signed [CW-1:0] cx [NUM_POINTS+1];
	logic signed [CW-1:0] cz [NUM_POINTS+1];
	fpec_tag_t            ct [NUM_POINTS+1];

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign enclosed  = enclosed_q;
	assign r2        = radius_q * radius_q;
	assign done_fire = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_BITS'(RADIUS_RESET);
		end else if (cfg_valid) begin
			radius_q <= radius;
		end
	end

	// five compare-exchange network per axis
	always_comb begin
		sx_n[0] = first_x;  sx_n[1] = second_x; sx_n[2] = third_x; sx_n[3] = fourth_x;
		sz_n[0] = first_z;  sz_n[1] = second_z; sz_n[2] = third_z; sz_n[3] = fourth_z;
		tmp = '0;
		if (sx_n[0] > sx_n[1]) begin tmp = sx_n[0]; sx_n[0] = sx_n[1]; sx_n[1] = tmp; end
		if (sx_n[2] > sx_n[3]) begin tmp = sx_n[2]; sx_n[2] = sx_n[3]; sx_n[3] = tmp; end
		if (sx_n[0] > sx_n[2]) begin tmp = sx_n[0]; sx_n[0] = sx_n[2]; sx_n[2] = tmp; end
		if (sx_n[1] > sx_n[3]) begin tmp = sx_n[1]; sx_n[1] = sx_n[3]; sx_n[3] = tmp; end
		if (sx_n[1] > sx_n[2]) begin tmp = sx_n[1]; sx_n[1] = sx_n[2]; sx_n[2] = tmp; end
		if (sz_n[0] > sz_n[1]) begin tmp = sz_n[0]; sz_n[0] = sz_n[1]; sz_n[1] = tmp; end
		if (sz_n[2] > sz_n[3]) begin tmp = sz_n[2]; sz_n[2] = sz_n[3]; sz_n[3] = tmp; end
		if (sz_n[0] > sz_n[2]) begin tmp = sz_n[0]; sz_n[0] = sz_n[2]; sz_n[2] = tmp; end
		if (sz_n[1] > sz_n[3]) begin tmp = sz_n[1]; sz_n[1] = sz_n[3]; sz_n[3] = tmp; end
		if (sz_n[1] > sz_n[2]) begin tmp = sz_n[1]; sz_n[1] = sz_n[2]; sz_n[2] = tmp; end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			px_q[0] <= first_x;  pz_q[0] <= first_z;
			px_q[1] <= second_x; pz_q[1] <= second_z;
			px_q[2] <= third_x;  pz_q[2] <= third_z;
			px_q[3] <= fourth_x; pz_q[3] <= fourth_z;
			for (int i = 0; i < NUM_POINTS; i++) begin
				sx_q[i] <= sx_n[i];
				sz_q[i] <= sz_n[i];
			end
		end
	end

	fpec_pair_check #(
		.COORD_BITS (COORD_BITS),
		.RADIUS_BITS(RADIUS_BITS)
	) u_pair (
		.ax    (px_q[PAIR_A[pair_q]]),
		.az    (pz_q[PAIR_A[pair_q]]),
		.bx    (px_q[PAIR_B[pair_q]]),
		.bz    (pz_q[PAIR_B[pair_q]]),
		.radius(radius_q),
		.reject(reject)
	);

	always_comb begin
		rad_w = {{(CW-RADIUS_BITS){1'b0}}, radius_q};
		xlo = {{(CW-COORD_BITS){sx_q[3][COORD_BITS-1]}}, sx_q[3]} - rad_w;
		xhi = {{(CW-COORD_BITS){sx_q[0][COORD_BITS-1]}}, sx_q[0]} + rad_w;
		zlo = {{(CW-COORD_BITS){sz_q[3][COORD_BITS-1]}}, sz_q[3]} - rad_w;
		zhi = {{(CW-COORD_BITS){sz_q[0][COORD_BITS-1]}}, sz_q[0]} + rad_w;
	end

	// chain of distance cells
	assign cx[0]       = x_q;
	assign cz[0]       = z_q;
	assign ct[0].valid = (state_q == S_SCAN);
	assign ct[0].ok    = 1'b1;

	for (genvar g = 0; g < NUM_POINTS; g++) begin : g_cell
		fpec_cell #(
			.COORD_BITS (COORD_BITS),
			.RADIUS_BITS(RADIUS_BITS),
			.CW         (CW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.load   (state_q == S_PAIR),
			.px     (sx_q[g]),
			.pz     (sz_q[g]),
			.r2     (r2),
			.x_in   (cx[g]),
			.z_in   (cz[g]),
			.tag_in (ct[g]),
			.x_out  (cx[g+1]),
			.z_out  (cz[g+1]),
			.tag_out(ct[g+1])
		);
	end

	assign hit_now   = ct[NUM_POINTS].valid && ct[NUM_POINTS].ok;
	assign last_cand = (x_q == xhi_q) && (z_q == zhi_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pair_q      <= '0;
			drain_q     <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (done_fire) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (hit_now) hit_q <= 1'b1;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						hit_q   <= 1'b0;
						pair_q  <= '0;
						state_q <= S_PAIR;
					end
				end
				S_PAIR: begin
					if (reject) begin
						state_q <= S_DONE;
					end else if (pair_q == 3'(NUM_PAIRS - 1)) begin
						state_q <= ((xlo <= xhi) && (zlo <= zhi)) ? S_SCAN : S_DONE;
					end else begin
						pair_q <= pair_q + 3'd1;
					end
				end
				S_SCAN: begin
					// stop issuing on the last centre or once a fitting centre reaches the chain end
					if (last_cand || hit_now || hit_q) begin
						drain_q <= '0;
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (drain_q == DW'(NUM_POINTS)) state_q <= S_DONE;
					else drain_q <= drain_q + DW'(1);
				end
				S_DONE: begin
					if (done_fire) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_PAIR) begin
			x_q   <= xlo;
			z_q   <= zlo;
			xlo_q <= xlo;
			xhi_q <= xhi;
			zlo_q <= zlo;
			zhi_q <= zhi;
		end else if (state_q == S_SCAN) begin
			if (x_q == xhi_q) begin
				x_q <= xlo_q;
				z_q <= z_q + CW'(1);
			end else begin
				x_q <= x_q + CW'(1);
			end
		end
		if (done_fire) enclosed_q <= hit_q;
	end

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state register not one-hot");
	a_scan_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (x_q >= xlo_q && x_q <= xhi_q && z_q >= zlo_q && z_q <= zhi_q))
		else $error("candidate centre outside window");
	a_chain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |-> !ct[NUM_POINTS].valid)
		else $error("chain not drained at result");
	a_accept_pair: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == S_PAIR) && !hit_q)
		else $error("transfer did not start pair test");

endmodule
